FILE: rtl/ppc_pkg.sv
// package: shared widths, constants and the cordic angle table for the pose controller
package ppc_pkg;

    localparam int CordicStages = 16;
    localparam int StageCount   = (CordicStages > 32) ? 32 : CordicStages;

    // cordic datapath width: 33-bit offset, guard bits, growth
    localparam int GuardBits = 4;
    localparam int CW        = 40;
    localparam int ZW        = 33;

    localparam logic signed [ZW-1:0] HalfPiQ29  = 33'sd843314857;
    localparam logic signed [17:0]   PiQ13      = 18'sd25736;
    localparam logic signed [17:0]   TwoPiQ13   = 18'sd51472;
    localparam logic [23:0]          InvGainQ24 = 24'd10188014;

    // register indexes
    typedef enum logic [2:0] {
        REG_GOAL_X     = 3'd0,
        REG_GOAL_Y     = 3'd1,
        REG_GAIN_RHO   = 3'd2,
        REG_GAIN_ALPHA = 3'd3,
        REG_GAIN_BETA  = 3'd4,
        REG_REACH_THR  = 3'd5
    } t_reg_idx;

    // atan(2^-i) in q3.29
    function automatic logic signed [ZW-1:0] atan_q29(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                5'd0:  v = 33'sd421657428;
                5'd1:  v = 33'sd248918915;
                5'd2:  v = 33'sd131521918;
                5'd3:  v = 33'sd66762579;
                5'd4:  v = 33'sd33510843;
                5'd5:  v = 33'sd16771758;
                5'd6:  v = 33'sd8387925;
                5'd7:  v = 33'sd4194219;
                5'd8:  v = 33'sd2097141;
                5'd9:  v = 33'sd1048575;
                5'd30: v = 33'sd0;
                5'd31: v = 33'sd0;
                default: v = ZW'(33'sd1 <<< (29 - i));
            endcase
            return v;
        end
    endfunction

    // payload traveling down the pipe
    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [15:0]   yaw;
    } t_cordic_beat;

endpackage

FILE: rtl/ppc_cordic_stage.sv
// one registered vectoring cordic iteration
module ppc_cordic_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [4:0]           i_shift,
    input  logic                 i_valid,
    input  ppc_pkg::t_cordic_beat i_beat,
    output logic                 o_valid,
    output ppc_pkg::t_cordic_beat o_beat
);

    logic                  r_valid;
    ppc_pkg::t_cordic_beat r_beat;
    ppc_pkg::t_cordic_beat n_beat;

    // rotate toward the x axis
    always_comb begin
        n_beat = i_beat;
        if (i_beat.y[ppc_pkg::CW-1]) begin
            n_beat.x = i_beat.x - (i_beat.y >>> i_shift);
            n_beat.y = i_beat.y + (i_beat.x >>> i_shift);
            n_beat.z = i_beat.z - ppc_pkg::atan_q29(i_shift);
        end else begin
            n_beat.x = i_beat.x + (i_beat.y >>> i_shift);
            n_beat.y = i_beat.y - (i_beat.x >>> i_shift);
            n_beat.z = i_beat.z + ppc_pkg::atan_q29(i_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: rtl/polar_pose_controller.sv
// top level: polar pose controller with pipelined cordic
// One pose enters per cycle unless the output is stalled. A pose passes stage a (offset
// to goal), stage b (quadrant fold), one registered cordic stage each of the 16, and
// stages c to f for angle wrap, gain products and saturation. The whole pipe advances
// together and holds when the output is stalled while a beat waits there.
module polar_pose_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_robot_x,
    input  logic signed [31:0] i_robot_y,
    input  logic signed [15:0] i_robot_yaw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity,
    output logic               o_goal_reached
);

    localparam int NS = ppc_pkg::StageCount;
    localparam int CW = ppc_pkg::CW;
    localparam int ZW = ppc_pkg::ZW;

    logic signed [31:0] r_goal_x, r_goal_y, w_gain_rho;
    logic signed [15:0] r_gain_rho, r_gain_alpha, r_gain_beta;
    logic [30:0]        r_reach_thr;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_gain_rho   <= '0;
            r_gain_alpha <= '0;
            r_gain_beta  <= '0;
            r_reach_thr  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppc_pkg::REG_GOAL_X:     r_goal_x     <= i_cfg_data;
                ppc_pkg::REG_GOAL_Y:     r_goal_y     <= i_cfg_data;
                ppc_pkg::REG_GAIN_RHO:   r_gain_rho   <= i_cfg_data[15:0];
                ppc_pkg::REG_GAIN_ALPHA: r_gain_alpha <= i_cfg_data[15:0];
                ppc_pkg::REG_GAIN_BETA:  r_gain_beta  <= i_cfg_data[15:0];
                ppc_pkg::REG_REACH_THR:  r_reach_thr  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end
    assign w_gain_rho = 32'(r_gain_rho);

    // whole pipe moves unless a finished beat is stalled at the output
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage a: offset to goal
    logic                 r_a_valid;
    logic signed [32:0]   r_a_ex, r_a_ey;
    logic signed [15:0]   r_a_yaw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else if (w_en) r_a_valid <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ex  <= 33'(r_goal_x) - 33'(i_robot_x);
            r_a_ey  <= 33'(r_goal_y) - 33'(i_robot_y);
            r_a_yaw <= i_robot_yaw;
        end
    end

    // stage b: left half plane fold and guard scaling
    logic                  r_b_valid;
    ppc_pkg::t_cordic_beat r_b_beat, n_b_beat;
    always_comb begin
        n_b_beat.zero = (r_a_ex == '0) && (r_a_ey == '0);
        n_b_beat.yaw  = r_a_yaw;
        if (r_a_ex[32]) begin
            if (!r_a_ey[32]) begin
                n_b_beat.x = CW'(r_a_ey) <<< ppc_pkg::GuardBits;
                n_b_beat.y = (-CW'(r_a_ex)) <<< ppc_pkg::GuardBits;
                n_b_beat.z = ppc_pkg::HalfPiQ29;
            end else begin
                n_b_beat.x = (-CW'(r_a_ey)) <<< ppc_pkg::GuardBits;
                n_b_beat.y = CW'(r_a_ex) <<< ppc_pkg::GuardBits;
                n_b_beat.z = -ppc_pkg::HalfPiQ29;
            end
        end else begin
            n_b_beat.x = CW'(r_a_ex) <<< ppc_pkg::GuardBits;
            n_b_beat.y = CW'(r_a_ey) <<< ppc_pkg::GuardBits;
            n_b_beat.z = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_valid <= 1'b0;
        else if (w_en) r_b_valid <= r_a_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_b_beat <= n_b_beat;
    end

    // cordic stages
    logic                  w_cv [NS+1];
    ppc_pkg::t_cordic_beat w_cb [NS+1];
    assign w_cv[0] = r_b_valid;
    assign w_cb[0] = r_b_beat;
    for (genvar g = 0; g < NS; g++) begin : g_cordic
        ppc_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (5'(g)),
            .i_valid (w_cv[g]),
            .i_beat  (w_cb[g]),
            .o_valid (w_cv[g+1]),
            .o_beat  (w_cb[g+1])
        );
    end

    // stage c: bearing rounding, alpha wrap, magnitude clamp
    ppc_pkg::t_cordic_beat w_cf;
    logic signed [ZW-1:0]  w_zr;
    logic signed [17:0]    w_bear, w_al0, w_al1, w_al2;
    logic [CW-2:0]         w_xpos;
    logic                  r_c_valid;
    logic signed [17:0]    r_c_alpha;
    logic signed [15:0]    r_c_yaw;
    logic [CW-2:0]         r_c_x;
    assign w_cf   = w_cb[NS];
    assign w_zr   = w_cf.z + ZW'(32768);
    assign w_bear = w_cf.zero ? '0 : 18'(w_zr >>> 16);
    assign w_xpos = (w_cf.zero || w_cf.x[CW-1]) ? '0 : w_cf.x[CW-2:0];
    assign w_al0  = w_bear - 18'(w_cf.yaw);
    assign w_al1  = (w_al0 < -ppc_pkg::PiQ13) ? w_al0 + ppc_pkg::TwoPiQ13 : w_al0;
    assign w_al2  = (w_al1 > ppc_pkg::PiQ13) ? w_al1 - ppc_pkg::TwoPiQ13 : w_al1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_valid <= 1'b0;
        else if (w_en) r_c_valid <= w_cv[NS];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_alpha <= w_al2;
            r_c_yaw   <= w_cf.yaw;
            r_c_x     <= w_xpos;
        end
    end

    // stage d: beta wrap, rho product, gain products on angles
    logic signed [17:0] w_be0, w_be1, w_be2;
    logic [63:0]        w_rhop;
    logic               r_d_valid;
    logic [35:0]        r_d_rho;
    logic signed [33:0] r_d_pa, r_d_pb;
    assign w_be0  = -r_c_alpha - 18'(r_c_yaw);
    assign w_be1  = (w_be0 < -ppc_pkg::PiQ13) ? w_be0 + ppc_pkg::TwoPiQ13 : w_be0;
    assign w_be2  = (w_be1 > ppc_pkg::PiQ13) ? w_be1 - ppc_pkg::TwoPiQ13 : w_be1;
    assign w_rhop = 64'(r_c_x) * 64'(ppc_pkg::InvGainQ24) + 64'(1 << 27);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_valid <= 1'b0;
        else if (w_en) r_d_valid <= r_c_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rho <= w_rhop[63:28];
            r_d_pa  <= 34'(r_gain_alpha) * 34'(r_c_alpha);
            r_d_pb  <= 34'(r_gain_beta) * 34'(w_be2);
        end
    end

    // stage e: linear product, angular sum, reach compare
    logic signed [53:0] w_vp;
    logic signed [34:0] w_ws;
    logic               r_e_valid, r_e_reach;
    logic signed [53:0] r_e_vp;
    logic signed [34:0] r_e_ws;
    assign w_vp = 54'(w_gain_rho) * $signed({18'd0, r_d_rho}) + 54'sd2048;
    assign w_ws = 35'(r_d_pa) + 35'(r_d_pb) + 35'sd256;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_valid <= 1'b0;
        else if (w_en) r_e_valid <= r_d_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_vp    <= w_vp;
            r_e_ws    <= w_ws;
            r_e_reach <= (r_d_rho < 36'(r_reach_thr));
        end
    end

    // stage f: rounding shift and saturation into the output register
    logic signed [41:0] w_v;
    logic signed [25:0] w_w;
    logic               r_o_valid, r_o_reach;
    logic signed [31:0] r_o_v, r_o_w;
    assign w_v = 42'(r_e_vp >>> 12);
    assign w_w = 26'(r_e_ws >>> 9);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (w_en) r_o_valid <= r_e_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_v > 42'sd2147483647)       r_o_v <= 32'sh7FFFFFFF;
            else if (w_v < -42'sd2147483648) r_o_v <= 32'sh80000000;
            else                             r_o_v <= 32'(w_v);
            r_o_w     <= 32'(w_w);
            r_o_reach <= r_e_reach;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_linear_velocity  = r_o_v;
    assign o_angular_velocity = r_o_w;
    assign o_goal_reached     = r_o_reach;

endmodule

FILE: rtl/ppc_checker.sv
// port checker for the pose controller, bound to the top level
module ppc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_linear_velocity,
    input logic [31:0] o_angular_velocity,
    input logic        o_goal_reached
);

    // input side stalls only while an output beat is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // held output beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_linear_velocity)
            && $stable(o_angular_velocity) && $stable(o_goal_reached)))
        else $error("stalled output beat changed");

    // no output beat right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind polar_pose_controller ppc_checker u_ppc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_linear_velocity  (o_linear_velocity),
    .o_angular_velocity (o_angular_velocity),
    .o_goal_reached     (o_goal_reached)
);

FILE: tb/tb_polar_pose_controller.sv
// testbench: polar pose controller against its own fixed-point predictor
module tb_polar_pose_controller;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_robot_x;
    logic signed [31:0] i_robot_y;
    logic signed [15:0] i_robot_yaw;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_linear_velocity;
    logic signed [31:0] o_angular_velocity;
    logic               o_goal_reached;

    polar_pose_controller u_top (.*);

    typedef struct {
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic               reached;
    } t_cmd;

    // index that maps to no register
    localparam logic [2:0] UnusedIdx = 3'd7;

    // predictor copy of the registers
    logic signed [31:0] goal_x_q, goal_y_q;
    logic signed [15:0] k_rho_q, k_alpha_q, k_beta_q;
    logic [30:0]        reach_q;

    t_cmd   cmd_queue[$];
    int     mismatches;
    int     checked;
    int     idle_cycles;
    bit     rx_hold;
    bit     quiet;
    bit     sink_idle_en;
    longint atan_tab[32];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor shift for signed values
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_pi(longint a);
        if (a < -25736) a += 51472;
        if (a > 25736) a -= 51472;
        return a;
    endfunction

    // command expected for one pose
    function automatic t_cmd predict_cmd(logic signed [31:0] rx, logic signed [31:0] ry,
                                         logic signed [15:0] yaw);
        longint ex, ey, x, y, z, t, bearing, rho, alpha, beta, acc;
        t_cmd   c;
        ex = longint'(goal_x_q) - longint'(rx);
        ey = longint'(goal_y_q) - longint'(ry);
        if (ex == 0 && ey == 0) begin
            bearing = 0;
            rho = 0;
        end else begin
            z = 0;
            if (ex < 0) begin
                if (ey >= 0) begin
                    x = ey; y = -ex; z = 843314857;
                end else begin
                    x = -ey; y = ex; z = -843314857;
                end
            end else begin
                x = ex; y = ey;
            end
            x = x * 16;
            y = y * 16;
            for (int i = 0; i < ppc_pkg::StageCount; i++) begin
                t = x;
                if (y < 0) begin
                    x = x - fshr(y, i); y = y + fshr(t, i); z -= atan_tab[i];
                end else begin
                    x = x + fshr(y, i); y = y - fshr(t, i); z += atan_tab[i];
                end
            end
            bearing = fshr(z + 32768, 16);
            if (x < 0) x = 0;
            rho = longint'((64'(x) * 64'd10188014 + 64'd134217728) >> 28);
        end
        alpha = wrap_pi(bearing - longint'(yaw));
        beta  = wrap_pi(-alpha - longint'(yaw));
        c.lin = 32'(sat32(fshr(longint'(k_rho_q) * rho + 2048, 12)));
        acc = longint'(k_alpha_q) * alpha + longint'(k_beta_q) * beta + 256;
        c.ang = 32'(sat32(fshr(acc, 9)));
        c.reached = (rho < longint'(reach_q));
        return c;
    endfunction

    // register write, block idle
    task automatic write_reg(ppc_pkg::t_reg_idx idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            ppc_pkg::REG_GOAL_X:     goal_x_q = val;
            ppc_pkg::REG_GOAL_Y:     goal_y_q = val;
            ppc_pkg::REG_GAIN_RHO:   k_rho_q = val[15:0];
            ppc_pkg::REG_GAIN_ALPHA: k_alpha_q = val[15:0];
            ppc_pkg::REG_GAIN_BETA:  k_beta_q = val[15:0];
            ppc_pkg::REG_REACH_THR:  reach_q = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] gx, logic [31:0] gy, logic [15:0] kr,
                           logic [15:0] ka, logic [15:0] kb, logic [30:0] th);
        write_reg(ppc_pkg::REG_GOAL_X, gx);
        write_reg(ppc_pkg::REG_GOAL_Y, gy);
        write_reg(ppc_pkg::REG_GAIN_RHO, {{16{kr[15]}}, kr});
        write_reg(ppc_pkg::REG_GAIN_ALPHA, {{16{ka[15]}}, ka});
        write_reg(ppc_pkg::REG_GAIN_BETA, {{16{kb[15]}}, kb});
        write_reg(ppc_pkg::REG_REACH_THR, {1'b0, th});
    endtask

    // stop sending and drain the pipe before touching registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (cmd_queue.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // send one pose beat, random gaps unless quiet; valid stays up for the next beat
    task automatic send_pose(logic signed [31:0] rx, logic signed [31:0] ry,
                             logic signed [15:0] yaw);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_robot_x   <= rx;
        i_robot_y   <= ry;
        i_robot_yaw <= yaw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cmd_queue.insert(cmd_queue.size(), predict_cmd(rx, ry, yaw));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_yaw();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    // random gains and goal, small and full scale mixed
    task automatic random_config();
        set_all(rand_pos(), rand_pos(),
                16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8192)),
                16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8192)),
                16'($urandom_range(0, 3) == 0 ? $urandom()
                    : 32'($signed($urandom_range(0, 8192)) - 8192)),
                $urandom_range(0, 1) ? 31'($urandom()) : 31'($urandom_range(0, 2000000)));
    endtask

    task automatic test_directed();
        set_all(32'd0, 32'd0, 16'h1000, 16'h1000, 16'hF000, 31'd65536);
        send_pose(0, 0, 16'sd0);                  // zero offset
        send_pose(0, 0, 16'sh7FFF);               // yaw out of range
        send_pose(0, 0, 16'sh8000);
        send_pose(-65536, 0, 16'sd25736);         // right half, ey zero
        send_pose(65536, 65536, -16'sd25736);     // left half, ey negative
        send_pose(65536, -65536, 16'sd0);         // left half, ey positive
        send_pose(65536, 0, 16'sd0);              // left half, ey zero
        send_pose(-65536, 65536, 16'sd100);       // right half
        send_pose(0, -65536, 16'sd0);
        send_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0);
        send_pose(32'sh8000_0000, 32'sh8000_0000, 16'sd0);
        wait_idle();
        set_all(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF);
        send_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF);
        send_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000);
        send_pose(0, 0, -16'sd25736);
        wait_idle();
        set_all(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 31'd0);
        send_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd25736);
        send_pose(32'sh8000_0000, 32'sh7FFF_FFFF, -16'sd25736);
        send_pose(0, 0, 16'sh8000);
        wait_idle();
        // unknown register index is ignored
        i_cfg_we <= 1'b1; i_cfg_idx <= UnusedIdx; i_cfg_data <= 32'hFFFF_FFFF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_pose(12345, -6789, 16'sd1000);
        wait_idle();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            random_config();
            for (int n = 0; n < per_phase; n++)
                send_pose(rand_pos(), rand_pos(), rand_yaw());
            wait_idle();
        end
    endtask

    // long receiver hold so the pipe fills and back-pressures
    task automatic test_backpressure();
        random_config();
        rx_hold = 1'b1;
        fork
            begin
                repeat (120) @(negedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        for (int n = 0; n < 60; n++)
            send_pose(rand_pos(), rand_pos(), rand_yaw());
        wait_idle();
    endtask

    // result stall generator
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_stall <= 1'b1;
        end else if (sink_idle_en && !quiet && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            sink_idle_en = 1'b0;
            fork
                begin
                    repeat ($urandom_range(1, 14)) @(negedge i_clk);
                    sink_idle_en = 1'b1;
                end
            join_none
        end else if (sink_idle_en || quiet) begin
            i_stall <= 1'b0;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_cmd e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cmd_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                e = cmd_queue.pop_front();
                checked++;
                if (e.lin !== o_linear_velocity || e.ang !== o_angular_velocity
                        || e.reached !== o_goal_reached) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp v=%0d w=%0d g=%0b got v=%0d w=%0d g=%0b",
                                 e.lin, e.ang, e.reached, o_linear_velocity,
                                 o_angular_velocity, o_goal_reached);
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 5000) begin
            $display("tb_polar_pose_controller: done, errors");
            $finish;
        end
    end

    initial begin
        atan_tab = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
                     8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
                     32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
                     8, 4, 2, 1, 0, 0};
        mismatches = 0; checked = 0; idle_cycles = 0;
        rx_hold = 1'b0; quiet = 1'b0; sink_idle_en = 1'b1;
        goal_x_q = 0; goal_y_q = 0; k_rho_q = 0; k_alpha_q = 0; k_beta_q = 0; reach_q = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = 3'd0; i_cfg_data = 32'd0;
        i_valid = 1'b0; i_stall = 1'b1; i_robot_x = 0; i_robot_y = 0; i_robot_yaw = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(10, 110);
        quiet = 1'b1;
        test_random(2, 60);
        wait_idle();
        $display("checked %0d pose commands: corner poses, all quadrants, gain extremes,",
                 checked);
        $display("back-pressure and random idling on both channels");
        if (mismatches == 0 && cmd_queue.size() == 0) begin
            $display("tb_polar_pose_controller: done, clean");
        end else begin
            $display("tb_polar_pose_controller: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ppc_pkg.sv
rtl/ppc_cordic_stage.sv
rtl/polar_pose_controller.sv
rtl/ppc_checker.sv
tb/tb_polar_pose_controller.sv
